// ===== rtl/uer_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types and constants of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  localparam int unsigned TRIGGER_HIGH_TICKS_DEF = 10;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 1'b1;

  localparam int unsigned DIST_W    = 16;
  localparam int unsigned ELAPSED_W = 19;
  localparam int unsigned TCNT_W    = 4;

  localparam logic [DIST_W-1:0]    MAX_DIST_MIN = 16'd500;
  localparam logic [DIST_W-1:0]    MAX_DIST_RST = 16'd4000;
  localparam logic [ELAPSED_W-1:0] LIMIT_RST    = 19'd23200;
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 19'h7FFFF;
  localparam logic [TCNT_W-1:0]    TRIG_LOW_TICKS = 4'd2;

  // limit = floor(md * 29 / 5) as (md * 29 * ceil(2^24 / 5)) >> 24
  localparam int unsigned LIMIT_RECIP_W = 27;
  localparam int unsigned LIMIT_SHIFT   = 24;
  localparam logic [LIMIT_RECIP_W-1:0] LIMIT_RECIP = 27'd97307876;

  // distance = floor(d * 5 / 29) as (d * 5 * ceil(2^27 / 29)) >> 27
  localparam int unsigned DIST_RECIP_W = 25;
  localparam int unsigned DIST_SHIFT   = 27;
  localparam logic [DIST_RECIP_W-1:0] DIST_RECIP = 25'd23140990;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_WAIT_PREV = 3'd1,
    PH_TRIG_LOW  = 3'd2,
    PH_TRIG_HIGH = 3'd3,
    PH_WAIT_RISE = 3'd4,
    PH_MEASURE   = 3'd5
  } phase_t;

  typedef struct packed {
    logic cmd;
    logic echo_level;
  } uer_in_t;

  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              result_valid;
    logic [DIST_W-1:0] distance;
    logic              timed_out;
  } uer_out_t;

  typedef struct packed {
    logic                 trigger_level;
    logic                 busy_res;
    logic                 result_valid;
    logic                 timed_out;
    logic [ELAPSED_W-1:0] duration;
  } uer_meas_t;

endpackage
`default_nettype wire

// ===== rtl/uer_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uer_in_if
// Input tick channel: valid/ready handshake carrying command and echo level.
// ----------------------------------------------------------------------------
interface uer_in_if import uer_pkg::*; ();
  logic    valid;
  logic    ready;
  uer_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/uer_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uer_out_if
// Result channel: valid/ready handshake carrying one result per tick.
// ----------------------------------------------------------------------------
interface uer_out_if import uer_pkg::*; ();
  logic     valid;
  logic     ready;
  uer_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/uer_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uer_cfg
// Configuration registers and the registered timeout limit derived from them.
// ----------------------------------------------------------------------------
module uer_cfg import uer_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  enable,
  output logic [ELAPSED_W-1:0]  limit
);

  localparam int unsigned PROD_W = DIST_W + LIMIT_RECIP_W;

  logic                 enable_r;
  logic [DIST_W-1:0]    max_dist_r;
  logic [ELAPSED_W-1:0] limit_r;
  logic [PROD_W-1:0]    lim_prod;
  logic [DIST_W-1:0]    wr_dist;

  assign wr_dist  = (cfg_wdata[DIST_W-1:0] < MAX_DIST_MIN) ? MAX_DIST_MIN
                                                           : cfg_wdata[DIST_W-1:0];
  assign lim_prod = PROD_W'(max_dist_r) * PROD_W'(LIMIT_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      max_dist_r <= MAX_DIST_RST;
      limit_r    <= LIMIT_RST;
    end else begin
      limit_r <= lim_prod[LIMIT_SHIFT +: ELAPSED_W];
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_ENABLE:   enable_r   <= cfg_wdata[0];
          CFG_MAX_DIST: max_dist_r <= wr_dist;
          default: ;
        endcase
      end
    end
  end

  assign enable = enable_r;
  assign limit  = limit_r;

endmodule
`default_nettype wire

// ===== rtl/uer_seq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uer_seq
// Input register and the measurement sequencer; one tick per cycle while meas_ready allows.
// ----------------------------------------------------------------------------
module uer_seq import uer_pkg::*; #(
  parameter int unsigned TrigHighTicks = TRIGGER_HIGH_TICKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  uer_in_if.sink               in_ch,
  input  logic                 enable,
  input  logic [ELAPSED_W-1:0] limit,
  output logic                 meas_valid,
  input  logic                 meas_ready,
  output uer_meas_t            meas
);

  localparam logic [TCNT_W-1:0] TrigHigh = TCNT_W'(TrigHighTicks);

  logic                 s0_valid_r;
  uer_in_t              s0_data_r;
  logic                 s0_adv;

  phase_t               phase_r, phase_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [TCNT_W-1:0]    tcnt_r, tcnt_nxt, tcnt_inc;

  logic                 meas_valid_r;
  uer_meas_t            meas_r, meas_nxt;

  assign s0_adv      = s0_valid_r && (!meas_valid_r || meas_ready);
  assign in_ch.ready = !s0_valid_r || s0_adv;

  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign tcnt_inc    = tcnt_r + 1'b1;

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    tcnt_nxt    = tcnt_r;
    meas_nxt    = '0;
    unique case (phase_r)
      PH_WAIT_PREV: begin
        elapsed_nxt = elapsed_inc;
        if (!s0_data_r.echo_level) begin
          phase_nxt = PH_TRIG_LOW;
          tcnt_nxt  = '0;
        end else if (elapsed_inc > limit) begin
          meas_nxt.result_valid = 1'b1;
          meas_nxt.timed_out    = 1'b1;
          meas_nxt.duration     = limit;
          phase_nxt             = PH_IDLE;
        end
      end
      PH_TRIG_LOW: begin
        elapsed_nxt = elapsed_inc;
        tcnt_nxt    = tcnt_inc;
        if (tcnt_inc >= TRIG_LOW_TICKS) begin
          phase_nxt = PH_TRIG_HIGH;
          tcnt_nxt  = '0;
        end
      end
      PH_TRIG_HIGH: begin
        meas_nxt.trigger_level = 1'b1;
        elapsed_nxt            = elapsed_inc;
        tcnt_nxt               = tcnt_inc;
        if (tcnt_inc >= TrigHigh) begin
          phase_nxt = PH_WAIT_RISE;
          tcnt_nxt  = '0;
        end
      end
      PH_WAIT_RISE: begin
        elapsed_nxt = elapsed_inc;
        if (s0_data_r.echo_level) begin
          phase_nxt   = PH_MEASURE;
          elapsed_nxt = '0;
        end else if (elapsed_inc > limit) begin
          meas_nxt.result_valid = 1'b1;
          meas_nxt.timed_out    = 1'b1;
          meas_nxt.duration     = limit;
          phase_nxt             = PH_IDLE;
        end
      end
      PH_MEASURE: begin
        elapsed_nxt = elapsed_inc;
        if (!s0_data_r.echo_level) begin
          meas_nxt.result_valid = 1'b1;
          meas_nxt.duration     = elapsed_inc;
          phase_nxt             = PH_IDLE;
        end else if (elapsed_inc > limit) begin
          meas_nxt.result_valid = 1'b1;
          meas_nxt.timed_out    = 1'b1;
          meas_nxt.duration     = limit;
          phase_nxt             = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (s0_data_r.cmd) begin
          if (!enable) begin
            meas_nxt.result_valid = 1'b1;
          end else begin
            phase_nxt   = PH_WAIT_PREV;
            elapsed_nxt = '0;
            tcnt_nxt    = '0;
          end
        end
      end
    endcase
    meas_nxt.busy_res = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r   <= 1'b0;
      meas_valid_r <= 1'b0;
      phase_r      <= PH_IDLE;
      elapsed_r    <= '0;
      tcnt_r       <= '0;
    end else begin
      if (in_ch.ready) begin
        s0_valid_r <= in_ch.valid;
      end
      if (s0_adv) begin
        meas_valid_r <= 1'b1;
        phase_r      <= phase_nxt;
        elapsed_r    <= elapsed_nxt;
        tcnt_r       <= tcnt_nxt;
      end else if (meas_ready) begin
        meas_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s0_data_r <= in_ch.data;
    end
    if (s0_adv) begin
      meas_r <= meas_nxt;
    end
  end

  assign meas_valid = meas_valid_r;
  assign meas       = meas_r;

endmodule
`default_nettype wire

// ===== rtl/uer_dist.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// uer_dist
// Converts the echo duration to millimetres and holds the output register.
// ----------------------------------------------------------------------------
module uer_dist import uer_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      meas_valid,
  output logic      meas_ready,
  input  uer_meas_t meas,
  uer_out_if.source out_ch
);

  localparam int unsigned PROD_W = ELAPSED_W + DIST_RECIP_W;
  localparam int unsigned QUOT_W = PROD_W - DIST_SHIFT;

  logic              out_valid_r;
  uer_out_t          out_r, out_nxt;
  logic [PROD_W-1:0] prod;
  logic [QUOT_W-1:0] quot;

  assign prod = PROD_W'(meas.duration) * PROD_W'(DIST_RECIP);
  assign quot = prod[PROD_W-1:DIST_SHIFT];

  always_comb begin
    out_nxt.trigger_level = meas.trigger_level;
    out_nxt.busy_res      = meas.busy_res;
    out_nxt.result_valid  = meas.result_valid;
    out_nxt.timed_out     = meas.timed_out;
    out_nxt.distance      = (quot > QUOT_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}}
                                                             : quot[DIST_W-1:0];
  end

  assign meas_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (meas_ready) begin
      out_valid_r <= meas_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (meas_ready && meas_valid) begin
      out_r <= out_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/ultrasonic_echo_ranger_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_core
// Ultrasonic echo ranger: trigger pulse generation and echo width ranging.
//
// in_ch carries one transaction per one-microsecond tick (start command and
// sampled echo level); out_ch returns exactly one transaction per tick with
// the trigger level, busy flag and, when a measurement ends, the distance
// in millimetres and the timeout flag. cfg_we/cfg_idx/cfg_wdata write the
// enable bit (index 0) and the maximum range (index 1, clamped to at least 500 mm).
// The block takes one transaction per cycle while out_ch does not stall. A
// result passes the input register, the sequencer register, then the
// distance multiplier into the output register.
// The timeout limit register is updated in the cycle after a range write.
// Reset empties the pipeline, returns the sequencer to idle, clears enable
// and sets the range to 4000 mm. When out_ch stalls, the output, sequencer
// and input registers fill in turn and in_ch.ready drops once all are full.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_core import uer_pkg::*; #(
  parameter int unsigned TrigHighTicks = TRIGGER_HIGH_TICKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  uer_in_if.sink                in_ch,
  uer_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic                 enable;
  logic [ELAPSED_W-1:0] limit;
  logic                 meas_valid;
  logic                 meas_ready;
  uer_meas_t            meas;

  uer_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .enable    (enable),
    .limit     (limit)
  );

  uer_seq #(
    .TrigHighTicks (TrigHighTicks)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .enable     (enable),
    .limit      (limit),
    .meas_valid (meas_valid),
    .meas_ready (meas_ready),
    .meas       (meas)
  );

  uer_dist u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .meas_valid (meas_valid),
    .meas_ready (meas_ready),
    .meas       (meas),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire
